/* src/assert_macros.svh */
// Assertion macros shared by the compensation block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the barometer compensation block.
package bpc_pkg;

    // Divider width and number of quotient-bit stages of the long division.
    localparam int DIV_BITS = 64;

    // Compensation constants.
    localparam logic [63:0] TEMP_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE  = 64'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;
    localparam int          P4_SHIFT    = 35;
    localparam int          ONE_SHIFT   = 47;

    // Configuration register indexes.
    localparam logic [7:0] REG_CAL_TEMP    = 8'd0;
    localparam logic [7:0] REG_CAL_PRESS_A = 8'd1;
    localparam logic [7:0] REG_CAL_PRESS_B = 8'd2;
    localparam logic [7:0] REG_CAL_PRESS_C = 8'd3;

    // Input item: one raw conversion pair.
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_out_item;

    // Unpacked pressure calibration coefficients.
    typedef struct packed {
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_press_cal;

    // Temperature results that ride along with the pressure work.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
    } t_temp_res;

endpackage

/* src/bpc_temp.sv */
`timescale 1ns / 1ps
// Five-stage temperature compensation pipeline producing fine and centi-degree values.
module bpc_temp
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [19:0] i_raw_t,
    input  logic [19:0] i_raw_p,
    input  logic [47:0] i_cal_temp,
    output logic        o_valid,
    output t_temp_res   o_res,
    output logic [19:0] o_raw_p
);

    logic [4:0]  r_vld;
    logic [19:0] r_rp [0:4];
    logic [31:0] r_a, r_d, r_m1, r_dd, r_tv1, r_m2, r_fine, r_fine_o, r_temp;
    logic [15:0] t1;
    logic [31:0] t2x, t3x, dd12;

    // Calibration slices, sign extended where the coefficient is signed.
    assign t1   = i_cal_temp[15:0];
    assign t2x  = {{16{i_cal_temp[31]}}, i_cal_temp[31:16]};
    assign t3x  = {{16{i_cal_temp[47]}}, i_cal_temp[47:32]};
    assign dd12 = 32'($signed(r_dd) >>> 12);

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= {15'd0, i_raw_t[19:3]} - {15'd0, t1, 1'b0};
            r_d      <= {16'd0, i_raw_t[19:4]} - {16'd0, t1};
            r_m1     <= r_a * t2x;
            r_dd     <= r_d * r_d;
            r_tv1    <= 32'($signed(r_m1) >>> 11);
            r_m2     <= dd12 * t3x;
            r_fine   <= r_tv1 + 32'($signed(r_m2) >>> 14);
            r_temp   <= 32'($signed(r_fine * 32'd5 + TEMP_ROUND) >>> 8);
            r_fine_o <= r_fine;
            r_rp[0]  <= i_raw_p;
            for (int k = 1; k < 5; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
        end
    end

    assign o_valid    = r_vld[4];
    assign o_res.temp = r_temp;
    assign o_res.fine = r_fine_o;
    assign o_raw_p    = r_rp[4];

endmodule

/* src/bpc_coef.sv */
`timescale 1ns / 1ps
// Seven-stage pressure pre-compensation: builds the division numerator and divisor.
module bpc_coef
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_temp_res   i_res,
    input  logic [19:0] i_raw_p,
    input  t_press_cal  i_cal,
    output logic        o_valid,
    output t_temp_res   o_res,
    output logic [63:0] o_num,
    output logic [63:0] o_den
);

    logic [6:0]         r_vld;
    t_temp_res          r_tr [0:6];
    logic [19:0]        r_rp [0:3];
    logic signed [32:0] r_v1;
    logic [63:0]        r_sq;
    logic signed [48:0] r_v1p5, r_v1p2, r_v1p5_c, r_v1p2_c, r_v1p2_d;
    logic signed [48:0] r_s6lo, r_s3lo;
    logic [31:0]        r_s6hi, r_s3hi;
    logic [63:0]        r_v2, r_x3, r_y, r_pn;
    logic [47:0]        r_ylo;
    logic [31:0]        r_yhi, r_nhi;
    logic [43:0]        r_nlo;
    logic [63:0]        r_den, r_num;
    logic [31:0]        abs_v1;
    logic [63:0]        y1;

    // Magnitude of the offset fine temperature; its square is exact in 64 bits.
    assign abs_v1 = r_v1[32] ? 32'(-r_v1) : r_v1[31:0];
    assign y1     = {16'd0, r_ylo} + {r_yhi, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Offset fine temperature.
            r_v1     <= $signed({i_res.fine[31], i_res.fine}) - $signed(TEMP_OFFSET[32:0]);
            // Square and linear products.
            r_sq     <= abs_v1 * abs_v1;
            r_v1p5   <= r_v1 * i_cal.p5;
            r_v1p2   <= r_v1 * i_cal.p2;
            // Square times coefficients, split into 32-bit halves.
            r_s6lo   <= $signed({1'b0, r_sq[31:0]}) * i_cal.p6;
            r_s6hi   <= r_sq[63:32] * {{16{i_cal.p6[15]}}, i_cal.p6};
            r_s3lo   <= $signed({1'b0, r_sq[31:0]}) * i_cal.p3;
            r_s3hi   <= r_sq[63:32] * {{16{i_cal.p3[15]}}, i_cal.p3};
            r_v1p5_c <= r_v1p5;
            r_v1p2_c <= r_v1p2;
            // Recombine the halves and gather the second term.
            r_v2     <= {{15{r_s6lo[48]}}, r_s6lo} + {r_s6hi, 32'd0}
                        + ({{15{r_v1p5_c[48]}}, r_v1p5_c} << 17)
                        + ({{48{i_cal.p4[15]}}, i_cal.p4} << P4_SHIFT);
            r_x3     <= {{15{r_s3lo[48]}}, r_s3lo} + {r_s3hi, 32'd0};
            r_v1p2_d <= r_v1p2_c;
            // Divisor base and numerator before scaling.
            r_y      <= (64'd1 << ONE_SHIFT) + 64'($signed(r_x3) >>> 8)
                        + ({{15{r_v1p2_d[48]}}, r_v1p2_d} << 12);
            r_pn     <= ((PRESS_BASE - {44'd0, r_rp[3]}) << 31) - r_v2;
            // Scaling products in halves.
            r_ylo    <= r_y[31:0] * i_cal.p1;
            r_yhi    <= r_y[63:32] * {16'd0, i_cal.p1};
            r_nlo    <= r_pn[31:0] * PRESS_SCALE;
            r_nhi    <= r_pn[63:32] * {20'd0, PRESS_SCALE};
            // Final divisor and numerator.
            r_den    <= 64'($signed(y1) >>> 33);
            r_num    <= {20'd0, r_nlo} + {r_nhi, 32'd0};
            // Side data delay lines.
            r_tr[0]  <= i_res;
            for (int k = 1; k < 7; k++) begin
                r_tr[k] <= r_tr[k-1];
            end
            r_rp[0]  <= i_raw_p;
            for (int k = 1; k < 4; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
        end
    end

    assign o_valid = r_vld[6];
    assign o_res   = r_tr[6];
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

/* src/bpc_div.sv */
`timescale 1ns / 1ps
// Pipelined signed 64-bit division, one quotient bit per stage, truncating toward zero.
module bpc_div
    import bpc_pkg::*;
    `include "assert_macros.svh"
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_temp_res   i_res,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_valid,
    output t_temp_res   o_res,
    output logic [63:0] o_quo,
    output logic        o_invalid
);

    typedef struct packed {
        t_temp_res res;
        logic      neg;
        logic      invalid;
    } t_side;

    logic [DIV_BITS:0]   r_vld;
    logic                r_vld_o;
    logic [63:0]         r_rem [0:DIV_BITS];
    logic [63:0]         r_dq  [0:DIV_BITS];
    logic [63:0]         r_ad  [0:DIV_BITS];
    t_side               r_side [0:DIV_BITS];
    logic [63:0]         r_quo;
    t_side               r_side_o;
    logic [64:0]         trial [0:DIV_BITS-1];
    logic                take  [0:DIV_BITS-1];

    // One restoring step per stage: shift in the next dividend bit and try the divisor.
    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            trial[k] = {r_rem[k], r_dq[k][63]};
            take[k]  = trial[k] >= {1'b0, r_ad[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[DIV_BITS-1:0], i_valid};
            r_vld_o <= r_vld[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Entry: magnitudes, result sign and the zero divisor flag.
            r_rem[0]          <= '0;
            r_dq[0]           <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_ad[0]           <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_side[0].res     <= i_res;
            r_side[0].neg     <= i_num[63] ^ i_den[63];
            r_side[0].invalid <= (i_den == 64'd0);
            for (int k = 0; k < DIV_BITS; k++) begin
                r_rem[k+1]  <= take[k] ? 64'(trial[k] - {1'b0, r_ad[k]}) : trial[k][63:0];
                r_dq[k+1]   <= {r_dq[k][62:0], take[k]};
                r_ad[k+1]   <= r_ad[k];
                r_side[k+1] <= r_side[k];
            end
            // Sign correction.
            r_quo    <= r_side[DIV_BITS].neg ? (64'd0 - r_dq[DIV_BITS]) : r_dq[DIV_BITS];
            r_side_o <= r_side[DIV_BITS];
        end
    end

    assign o_valid   = r_vld_o;
    assign o_res     = r_side_o.res;
    assign o_quo     = r_quo;
    assign o_invalid = r_side_o.invalid;

    // A finished division by a nonzero divisor leaves a remainder below the divisor.
    `ASSERT_ON_CLK(a_rem_below_div, i_clk, i_rst_n, (r_vld[DIV_BITS] && !r_side[DIV_BITS].invalid) |-> (r_rem[DIV_BITS] < r_ad[DIV_BITS]), "division remainder not below divisor")
    // The zero divisor flag matches the divisor carried along.
    `ASSERT_ON_CLK(a_invalid_den, i_clk, i_rst_n, r_vld[DIV_BITS] |-> (r_side[DIV_BITS].invalid == (r_ad[DIV_BITS] == 64'd0)), "zero divisor flag out of step")

endmodule

/* src/bpc_post.sv */
`timescale 1ns / 1ps
// Six-stage pressure post-compensation; its last stage is the result register.
module bpc_post
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_temp_res   i_res,
    input  logic [63:0] i_quo,
    input  logic        i_invalid,
    input  t_press_cal  i_cal,
    output logic        o_valid,
    output t_out_item   o_item
);

    typedef struct packed {
        t_temp_res res;
        logic      invalid;
    } t_side;

    logic [5:0]         r_vld;
    t_side              r_side [0:4];
    logic [63:0]        r_q    [0:3];
    logic [63:0]        r_ll, r_sq, r_q8, r_v1, r_v2, r_v2_d, r_sum;
    logic [31:0]        r_cross, r_q8hi, r_s9hi;
    logic signed [48:0] r_q8lo, r_s9lo;
    t_out_item          r_out;
    logic [63:0]        a13;
    logic [63:0]        s9;

    assign a13 = 64'($signed(i_quo) >>> 13);
    assign s9  = {{15{r_s9lo[48]}}, r_s9lo} + {r_s9hi, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Square of the shifted quotient in halves; both cross terms are equal.
            r_ll    <= a13[31:0] * a13[31:0];
            r_cross <= a13[31:0] * a13[63:32];
            r_q8lo  <= $signed({1'b0, i_quo[31:0]}) * i_cal.p8;
            r_q8hi  <= i_quo[63:32] * {{16{i_cal.p8[15]}}, i_cal.p8};
            // Recombine.
            r_sq    <= r_ll + {r_cross[30:0], 33'd0};
            r_q8    <= {{15{r_q8lo[48]}}, r_q8lo} + {r_q8hi, 32'd0};
            // Square times the quadratic coefficient.
            r_s9lo  <= $signed({1'b0, r_sq[31:0]}) * i_cal.p9;
            r_s9hi  <= r_sq[63:32] * {{16{i_cal.p9[15]}}, i_cal.p9};
            r_v2    <= 64'($signed(r_q8) >>> 19);
            // Correction terms.
            r_v1    <= 64'($signed(s9) >>> 25);
            r_v2_d  <= r_v2;
            r_sum   <= r_q[3] + r_v1 + r_v2_d;
            // Result register.
            r_out.temperature_centi <= r_side[4].res.temp;
            r_out.fine_temperature  <= r_side[4].res.fine;
            r_out.pressure_invalid  <= r_side[4].invalid;
            r_out.pressure_q24_8    <= r_side[4].invalid ? 32'd0
                : 32'(64'($signed(r_sum) >>> 8) + ({{48{i_cal.p7[15]}}, i_cal.p7} << 4));
            // Side data delay lines.
            r_q[0]              <= i_quo;
            r_side[0].res       <= i_res;
            r_side[0].invalid   <= i_invalid;
            for (int k = 1; k < 4; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = 1; k < 5; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[5];
    assign o_item  = r_out;

endmodule

/* src/barometer_temp_pressure_compensation.sv */
`timescale 1ns / 1ps
// Top level of the barometer temperature and pressure compensation pipeline.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_item (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_in_stall is low.
// Most of the depth is the long division's 64 quotient-bit stages, one quotient bit per stage.
// Reset clears the calibration registers and all valid bits.
// While a result waits under i_out_stall the whole pipeline holds and o_in_stall rises.
module barometer_temp_pressure_compensation
    import bpc_pkg::*;
    `include "assert_macros.svh"
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a, r_cal_press_b;
    logic [15:0] r_cal_press_c;
    t_press_cal  cal;
    logic        en;

    logic        tmp_valid, coef_valid, div_valid, div_invalid;
    t_temp_res   tmp_res, coef_res, div_res;
    logic [19:0] tmp_raw_p;
    logic [63:0] coef_num, coef_den, div_quo;

    // Calibration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CAL_TEMP:    r_cal_temp    <= i_cfg_data[47:0];
                REG_CAL_PRESS_A: r_cal_press_a <= i_cfg_data;
                REG_CAL_PRESS_B: r_cal_press_b <= i_cfg_data;
                REG_CAL_PRESS_C: r_cal_press_c <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Coefficient unpacking.
    assign cal.p1 = r_cal_press_a[15:0];
    assign cal.p2 = r_cal_press_a[31:16];
    assign cal.p3 = r_cal_press_a[47:32];
    assign cal.p4 = r_cal_press_a[63:48];
    assign cal.p5 = r_cal_press_b[15:0];
    assign cal.p6 = r_cal_press_b[31:16];
    assign cal.p7 = r_cal_press_b[47:32];
    assign cal.p8 = r_cal_press_b[63:48];
    assign cal.p9 = r_cal_press_c;

    // The pipeline advances unless a finished result is held by the consumer.
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    bpc_temp u_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_raw_t    (i_in_item.raw_temperature),
        .i_raw_p    (i_in_item.raw_pressure),
        .i_cal_temp (r_cal_temp),
        .o_valid    (tmp_valid),
        .o_res      (tmp_res),
        .o_raw_p    (tmp_raw_p)
    );

    bpc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (tmp_valid),
        .i_res   (tmp_res),
        .i_raw_p (tmp_raw_p),
        .i_cal   (cal),
        .o_valid (coef_valid),
        .o_res   (coef_res),
        .o_num   (coef_num),
        .o_den   (coef_den)
    );

    bpc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (coef_valid),
        .i_res     (coef_res),
        .i_num     (coef_num),
        .i_den     (coef_den),
        .o_valid   (div_valid),
        .o_res     (div_res),
        .o_quo     (div_quo),
        .o_invalid (div_invalid)
    );

    bpc_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (div_valid),
        .i_res     (div_res),
        .i_quo     (div_quo),
        .i_invalid (div_invalid),
        .i_cal     (cal),
        .o_valid   (o_out_valid),
        .o_item    (o_out_item)
    );

    // An invalid pressure is always reported as zero.
    `ASSERT_ON_CLK(a_invalid_zero, i_clk, i_rst_n, (o_out_valid && o_out_item.pressure_invalid) |-> (o_out_item.pressure_q24_8 == 32'd0), "invalid pressure not zero")
    // The input side only stalls behind a held result.
    `ASSERT_ON_CLK(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without a held result")
    // Reset empties the output.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
